// File: src/pif_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared constants and helpers for the printf integer formatter.
// No dependencies; imported by pif_bcd_conv and printf_integer_formatter.
package pif_pkg;

  localparam int ArgW      = 32;           // argument word width
  localparam int NumDigits = 10;           // digit slots, enough for 2^32-1 in decimal
  localparam int DigW      = 4 * NumDigits;
  localparam int ErrLen    = 5;            // length of "ERROR"

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharC     = 8'h63;
  localparam logic [7:0] CharD     = 8'h64;
  localparam logic [7:0] CharI     = 8'h69;
  localparam logic [7:0] CharU     = 8'h75;
  localparam logic [7:0] CharX     = 8'h78;
  localparam logic [7:0] CharXUp   = 8'h58;
  localparam logic [7:0] CharP     = 8'h70;

  // Lowercase hex character for one digit.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CharZero + {4'h0, nib};
    end else begin
      r = 8'h61 + {4'h0, nib - 4'd10};
    end
    return r;
  endfunction

  // Character of "ERROR" at a given position.
  function automatic logic [7:0] err_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = 8'h45;
      3'd3: r = 8'h4f;
      default: r = 8'h52;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/pif_bcd_conv.sv
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on pif_pkg for the argument and digit widths.
module pif_bcd_conv
  import pif_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [ArgW-1:0] bin_i,
  output logic                 done_o,
  output logic [DigW-1:0]      bcd_o
);

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [ArgW-1:0] bin_q, bin_d;
  logic [DigW-1:0] bcd_q, bcd_d;
  logic [DigW-1:0] adj;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int k = 0; k < NumDigits; k++) begin
      adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3 : bcd_q[4*k +: 4];
    end
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = 5'd0;
      bin_d = bin_i;
      bcd_d = '0;
    end else if (run_q) begin
      bcd_d = {adj[DigW-2:0], bin_q[ArgW-1]};
      bin_d = {bin_q[ArgW-2:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule
`default_nettype wire

// File: src/printf_integer_formatter.sv
`timescale 1ns / 1ps
`default_nettype none
// A literal, %c or %% is registered in the single-character state and then loaded into the
// output register; ERROR leaves at one character per cycle while the output is not stalled.
// %x strips up to 9 leading zero digits, one per cycle, then sizes the padding;
// %d/%u first wait for bit-serial BCD conversion.
// One request at a time; '%', width digits and NUL are taken without leaving the idle state.
// Reset (rst_ni low, asynchronous) returns to literal mode with width 0 and space fill.
module printf_integer_formatter
  import pif_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,   // [7:0] fmt_char, [39:8] arg_value
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] out_char
  output logic             m_axis_tlast_o    // last_of_run
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;  // take the next request
  localparam logic [2:0] S_ONE   = 3'd1;  // single character
  localparam logic [2:0] S_ERR   = 3'd2;  // spell out ERROR
  localparam logic [2:0] S_CONV  = 3'd3;  // wait for decimal conversion
  localparam logic [2:0] S_STRIP = 3'd4;  // drop leading zero digits
  localparam logic [2:0] S_SIGN  = 3'd5;  // minus sign
  localparam logic [2:0] S_PAD   = 3'd6;  // fill characters
  localparam logic [2:0] S_DIG   = 3'd7;  // digits, most significant first

  logic [2:0]      state_q, state_d;
  logic            in_dir_q, in_dir_d;
  logic [15:0]     width_q, width_d;
  logic            zf_q, zf_d;
  logic            neg_q, neg_d;
  logic [2:0]      idx_q, idx_d;
  logic [3:0]      rem_q, rem_d;
  logic [3:0]      pad_q, pad_d;
  logic [7:0]      char_q, char_d;
  logic [DigW-1:0] dig_q, dig_d;

  logic            out_valid_q;
  logic [7:0]      out_char_q;
  logic            out_last_q;

  logic            emit, emit_ok, emit_last;
  logic [7:0]      emit_char;

  logic            conv_start, conv_done;
  logic [ArgW-1:0] conv_bin;
  logic [DigW-1:0] conv_bcd;

  logic [7:0]      ch;
  logic [ArgW-1:0] arg;
  logic [15:0]     cnt;
  logic [3:0]      pad_new;

  assign ch  = s_axis_tdata_i[7:0];
  assign arg = s_axis_tdata_i[39:8];

  pif_bcd_conv u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .bin_i   (conv_bin),
    .done_o  (conv_done),
    .bcd_o   (conv_bcd)
  );

  // Padding counter: width less the digits beyond the first, less the sign.
  // Only a count of 2..15 pads, with one fill character fewer than the count.
  assign cnt     = width_q - {12'h000, rem_q - 4'd1} - {15'h0000, neg_q};
  assign pad_new = (cnt > 16'd1 && cnt < 16'd16) ? cnt[3:0] - 4'd1 : 4'd0;

  // A character may be loaded when the output slot is empty or drains this cycle.
  assign emit_ok = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d    = state_q;
    in_dir_d   = in_dir_q;
    width_d    = width_q;
    zf_d       = zf_q;
    neg_d      = neg_q;
    idx_d      = idx_q;
    rem_d      = rem_q;
    pad_d      = pad_q;
    char_d     = char_q;
    dig_d      = dig_q;
    emit       = 1'b0;
    emit_char  = char_q;
    emit_last  = 1'b0;
    conv_start = 1'b0;
    conv_bin   = arg;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (!in_dir_q) begin
            if (ch == CharNul) begin
              // End of format: clear the width and zero fill, emit nothing.
              width_d = 16'h0000;
              zf_d    = 1'b0;
            end else if (ch == CharPct) begin
              in_dir_d = 1'b1;
              width_d  = 16'h0000;
              zf_d     = 1'b0;
            end else begin
              char_d  = ch;
              state_d = S_ONE;
            end
          end else if (ch >= CharZero && ch <= CharNine) begin
            // Leading zero selects zero fill; width wraps at 16 bits.
            if (ch == CharZero && width_q == 16'h0000) begin
              zf_d = 1'b1;
            end
            width_d = (width_q << 3) + (width_q << 1) + {8'h00, ch - CharZero};
          end else begin
            in_dir_d = 1'b0;
            neg_d    = 1'b0;
            rem_d    = 4'(NumDigits);
            case (ch)
              CharC: begin
                char_d  = arg[7:0];
                state_d = S_ONE;
              end
              CharD, CharI: begin
                // Magnitude of a negative value; the most negative wraps onto itself.
                neg_d      = arg[ArgW-1];
                conv_bin   = arg[ArgW-1] ? (~arg + 32'd1) : arg;
                conv_start = 1'b1;
                state_d    = S_CONV;
              end
              CharU: begin
                conv_start = 1'b1;
                state_d    = S_CONV;
              end
              CharX, CharXUp, CharP: begin
                dig_d   = {{(DigW-ArgW){1'b0}}, arg};
                state_d = S_STRIP;
              end
              CharPct: begin
                char_d  = CharPct;
                state_d = S_ONE;
              end
              default: begin
                idx_d   = 3'd0;
                state_d = S_ERR;
                if (ch == CharNul) begin
                  width_d = 16'h0000;
                  zf_d    = 1'b0;
                end
              end
            endcase
          end
        end
      end

      S_ONE: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_char = char_q;
          emit_last = 1'b1;
          state_d   = S_IDLE;
        end
      end

      S_ERR: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_char = err_char(idx_q);
          emit_last = (idx_q == 3'(ErrLen - 1));
          idx_d     = idx_q + 3'd1;
          if (emit_last) begin
            state_d = S_IDLE;
          end
        end
      end

      S_CONV: begin
        if (conv_done) begin
          dig_d   = conv_bcd;
          state_d = S_STRIP;
        end
      end

      S_STRIP: begin
        // Shift out leading zeros, keeping at least one digit.
        if (dig_q[DigW-1 -: 4] == 4'h0 && rem_q > 4'd1) begin
          dig_d = {dig_q[DigW-5:0], 4'h0};
          rem_d = rem_q - 4'd1;
        end else begin
          pad_d = pad_new;
          if (neg_q && zf_q) begin
            state_d = S_SIGN;
          end else if (pad_new != 4'd0) begin
            state_d = S_PAD;
          end else if (neg_q) begin
            state_d = S_SIGN;
          end else begin
            state_d = S_DIG;
          end
        end
      end

      S_SIGN: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_char = CharMinus;
          neg_d     = 1'b0;
          state_d   = (pad_q != 4'd0) ? S_PAD : S_DIG;
        end
      end

      S_PAD: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_char = zf_q ? CharZero : CharSpace;
          pad_d     = pad_q - 4'd1;
          if (pad_q == 4'd1) begin
            state_d = neg_q ? S_SIGN : S_DIG;
          end
        end
      end

      S_DIG: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_char = hex_char(dig_q[DigW-1 -: 4]);
          emit_last = (rem_q == 4'd1);
          dig_d     = {dig_q[DigW-5:0], 4'h0};
          rem_d     = rem_q - 4'd1;
          if (emit_last) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_dir_q    <= 1'b0;
      width_q     <= 16'h0000;
      zf_q        <= 1'b0;
      neg_q       <= 1'b0;
      idx_q       <= 3'd0;
      rem_q       <= 4'd0;
      pad_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      in_dir_q <= in_dir_d;
      width_q  <= width_d;
      zf_q     <= zf_d;
      neg_q    <= neg_d;
      idx_q    <= idx_d;
      rem_q    <= rem_d;
      pad_q    <= pad_d;
      // Hold the character until taken; load a new one as the old one drains.
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    dig_q  <= dig_d;
    if (emit) begin
      out_char_q <= emit_char;
      out_last_q <= emit_last;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;

  // The converter finishes only while the sequencer is waiting for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_done |-> (state_q == S_CONV))
    else $error("BCD conversion finished outside the conversion wait");

  // Digit emission always has between one and ten digits left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIG) |-> (rem_q != 4'd0 && rem_q <= 4'(NumDigits)))
    else $error("digit count out of range");

  // Fill runs hold a count of 1..14.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PAD) |-> (pad_q != 4'd0 && pad_q != 4'd15))
    else $error("fill count out of range");

  // A request that ends its run returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_last) |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle after the last character");

endmodule
`default_nettype wire
